/* rtl/tksk_pkg.sv */
// Shared types, codes and helpers of the top-k sorted keeper.
`default_nettype none
package tksk_pkg;

	localparam int MAX_KEEP_DEF = 16;
	localparam int TAG_BITS_DEF = 16;

	localparam int KEY_W   = 64;
	localparam int TAG_W   = 16;
	localparam int CNT_W   = 5;
	localparam int RANK_W  = 4;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(16);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	localparam logic REG_KEEP_COUNT = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} st_t;

	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] fill;
	} cell_ctl_t;

	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] wcap;
		logic [CNT_W-1:0] cap;
	} cfg_t;

	typedef struct packed {
		logic                    kind;
		logic                    dropped;
		logic [TAG_W-1:0]        dropped_tag;
		logic [CNT_W-1:0]        held_count;
		logic                    entry_valid;
		logic signed [KEY_W-1:0] entry_key;
		logic [TAG_W-1:0]        entry_tag;
		logic [RANK_W-1:0]       rank;
		logic                    last;
	} res_t;

	function automatic logic [CNT_W-1:0] eff_cap(logic [CNT_W-1:0] kc, int maxk);
		logic [CNT_W-1:0] c;
		c = kc;
		if (c == '0)
			c = CNT_W'(1);
		if (int'(c) > maxk)
			c = CNT_W'(maxk);
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/tksk_cell.sv */
// One rank of the sorted chain: holds a key and tag, shifts down on insert.
`default_nettype none
module tksk_cell #(
	parameter int IDX    = 0,
	parameter int TAG_SW = 16
) (
	input  wire                                  clk,
	input  wire tksk_pkg::cell_ctl_t             ctl,
	input  wire logic signed [tksk_pkg::KEY_W-1:0] new_key,
	input  wire logic [TAG_SW-1:0]               new_tag,
	input  wire logic signed [tksk_pkg::KEY_W-1:0] prev_key,
	input  wire logic [TAG_SW-1:0]               prev_tag,
	input  wire logic                            prev_gt,
	output logic signed [tksk_pkg::KEY_W-1:0]    key,
	output logic [TAG_SW-1:0]                    tag,
	output logic                                 gt
);

	logic signed [tksk_pkg::KEY_W-1:0] key_q;
	logic [TAG_SW-1:0]                 tag_q;

	// at or past the insertion point
	assign gt  = (IDX >= int'(ctl.fill)) || (key_q < new_key);
	assign key = key_q;
	assign tag = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.wr && gt) begin
			key_q <= prev_gt ? prev_key : new_key;
			tag_q <= prev_gt ? prev_tag : new_tag;
		end
	end

endmodule
`default_nettype wire

/* rtl/tksk_apb.sv */
// APB register port holding the keep count.
`default_nettype none
module tksk_apb #(
	parameter int MAX_KEEP = tksk_pkg::MAX_KEEP_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tksk_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [tksk_pkg::DATA_W-1:0]   pwdata,
	output logic [tksk_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	output tksk_pkg::cfg_t                     cfg
);

	logic [tksk_pkg::CNT_W-1:0] keep_count_q;
	logic                       hit;

	assign pready  = 1'b1;
	assign hit     = (paddr[2] == tksk_pkg::REG_KEEP_COUNT);
	assign cfg.wr  = psel && penable && pwrite && pready && hit;
	assign cfg.wcap = tksk_pkg::eff_cap(pwdata[tksk_pkg::CNT_W-1:0], MAX_KEEP);
	assign cfg.cap  = tksk_pkg::eff_cap(keep_count_q, MAX_KEEP);
	assign prdata  = hit ? tksk_pkg::DATA_W'(keep_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tksk_pkg::KEEP_RESET;
		end else if (cfg.wr) begin
			keep_count_q <= pwdata[tksk_pkg::CNT_W-1:0];
		end
	end

endmodule
`default_nettype wire

/* rtl/top_k_sorted_keeper.sv */
// Top level of the top-k sorted keeper: cell chain, sequencer and result register.
//
//  channel | signals                                        | moves
//  in      | in_valid in_ready opcode key_value record_tag  | one item per handshake
//  out     | out_valid out_ready kind .. last               | one result per handshake
//  cfg     | psel penable pwrite paddr pwdata prdata pready | keep_count at 0x0
//
//  Insert: all cells compare in parallel and shift down in the same edge.
//  Readout: one result per cycle from the cell chain while out_ready holds, fill count results (one if empty).
//  A result sits in the output register; a new item enters when that register frees.
//  Reset clears the fill count and sets keep_count to 16; cell contents stay unset.
//  Stalls on out_ready hold the sequencer and the input channel.
`default_nettype none
module top_k_sorted_keeper #(
	parameter int MAX_KEEP = tksk_pkg::MAX_KEEP_DEF,
	parameter int TAG_BITS = tksk_pkg::TAG_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              opcode,
	input  wire logic signed [tksk_pkg::KEY_W-1:0] key_value,
	input  wire logic [tksk_pkg::TAG_W-1:0]        record_tag,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   kind,
	output logic                                   dropped,
	output logic [tksk_pkg::TAG_W-1:0]             dropped_tag,
	output logic [tksk_pkg::CNT_W-1:0]             held_count,
	output logic                                   entry_valid,
	output logic signed [tksk_pkg::KEY_W-1:0]      entry_key,
	output logic [tksk_pkg::TAG_W-1:0]             entry_tag,
	output logic [tksk_pkg::RANK_W-1:0]            rank,
	output logic                                   last,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tksk_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [tksk_pkg::DATA_W-1:0]       pwdata,
	output logic [tksk_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready
);

	localparam int TAG_SW = (TAG_BITS < tksk_pkg::TAG_W) ? TAG_BITS : tksk_pkg::TAG_W;

	tksk_pkg::cfg_t      cfg;
	tksk_pkg::cell_ctl_t ctl;
	tksk_pkg::st_t       state_q, state_d;
	tksk_pkg::res_t      res_q, res_d;

	logic                           ovalid_q;
	logic [tksk_pkg::CNT_W-1:0]     fill_q;
	logic [tksk_pkg::CNT_W-1:0]     rd_idx_q;
	logic                           out_free, in_fire, ins_fire, read_fire;
	logic                           full, ins_any, last_rd, res_load;
	logic [TAG_SW-1:0]              new_tag, last_tag, rd_tag;
	logic signed [tksk_pkg::KEY_W-1:0] rd_key;

	logic signed [tksk_pkg::KEY_W-1:0] cell_key [MAX_KEEP];
	logic [TAG_SW-1:0]                 cell_tag [MAX_KEEP];
	logic                              cell_gt  [MAX_KEEP];

	tksk_apb #(.MAX_KEEP(MAX_KEEP)) u_apb (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign out_free  = !ovalid_q || out_ready;
	assign in_ready  = (state_q == tksk_pkg::ST_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign ins_fire  = in_fire && (opcode == tksk_pkg::OP_INSERT);
	assign read_fire = in_fire && (opcode == tksk_pkg::OP_READ);
	assign new_tag   = record_tag[TAG_SW-1:0];
	assign full      = (fill_q >= cfg.cap);
	assign last_rd   = (rd_idx_q == fill_q - tksk_pkg::CNT_W'(1));

	assign ctl.wr   = ins_fire;
	assign ctl.fill = fill_q;

	genvar g;
	generate
		for (g = 0; g < MAX_KEEP; g++) begin : g_cell
			if (g == 0) begin : g_head
				tksk_cell #(.IDX(g), .TAG_SW(TAG_SW)) u_cell (
					.clk     (clk),
					.ctl     (ctl),
					.new_key (key_value),
					.new_tag (new_tag),
					.prev_key(key_value),
					.prev_tag(new_tag),
					.prev_gt (1'b0),
					.key     (cell_key[g]),
					.tag     (cell_tag[g]),
					.gt      (cell_gt[g])
				);
			end else begin : g_body
				tksk_cell #(.IDX(g), .TAG_SW(TAG_SW)) u_cell (
					.clk     (clk),
					.ctl     (ctl),
					.new_key (key_value),
					.new_tag (new_tag),
					.prev_key(cell_key[g-1]),
					.prev_tag(cell_tag[g-1]),
					.prev_gt (cell_gt[g-1]),
					.key     (cell_key[g]),
					.tag     (cell_tag[g]),
					.gt      (cell_gt[g])
				);
			end
		end
	endgenerate

	// pick the tail entry, the readout entry and whether the new key lands inside the list
	always_comb begin
		ins_any  = 1'b0;
		last_tag = '0;
		rd_tag   = '0;
		rd_key   = '0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (i < int'(fill_q) && cell_gt[i])
				ins_any = 1'b1;
			if (i == int'(fill_q) - 1)
				last_tag = last_tag | cell_tag[i];
			if (i == int'(rd_idx_q)) begin
				rd_tag = rd_tag | cell_tag[i];
				rd_key = rd_key | cell_key[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tksk_pkg::ST_IDLE: begin
				if (read_fire && fill_q != '0)
					state_d = tksk_pkg::ST_READ;
			end
			tksk_pkg::ST_READ: begin
				if (out_free && last_rd)
					state_d = tksk_pkg::ST_IDLE;
			end
			default: state_d = tksk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		res_d    = '0;
		res_load = 1'b0;
		unique case (state_q)
			tksk_pkg::ST_IDLE: begin
				if (ins_fire) begin
					res_load          = 1'b1;
					res_d.kind        = tksk_pkg::KIND_INSERT;
					res_d.dropped     = full;
					res_d.dropped_tag = full ?
						tksk_pkg::TAG_W'(ins_any ? last_tag : new_tag) : '0;
					res_d.held_count  = full ? fill_q : fill_q + tksk_pkg::CNT_W'(1);
					res_d.last        = 1'b1;
				end else if (read_fire && fill_q == '0) begin
					res_load   = 1'b1;
					res_d.kind = tksk_pkg::KIND_ENTRY;
					res_d.last = 1'b1;
				end
			end
			tksk_pkg::ST_READ: begin
				if (out_free) begin
					res_load          = 1'b1;
					res_d.kind        = tksk_pkg::KIND_ENTRY;
					res_d.held_count  = fill_q;
					res_d.entry_valid = 1'b1;
					res_d.entry_key   = rd_key;
					res_d.entry_tag   = tksk_pkg::TAG_W'(rd_tag);
					res_d.rank        = rd_idx_q[tksk_pkg::RANK_W-1:0];
					res_d.last        = last_rd;
				end
			end
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tksk_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
			fill_q   <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			if (cfg.wr) begin
				if (fill_q > cfg.wcap)
					fill_q <= cfg.wcap;
			end else if (ins_fire && !full) begin
				fill_q <= fill_q + tksk_pkg::CNT_W'(1);
			end
			if (read_fire)
				rd_idx_q <= '0;
			else if (state_q == tksk_pkg::ST_READ && out_free)
				rd_idx_q <= rd_idx_q + tksk_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res_d;
	end

	assign out_valid   = ovalid_q;
	assign kind        = res_q.kind;
	assign dropped     = res_q.dropped;
	assign dropped_tag = res_q.dropped_tag;
	assign held_count  = res_q.held_count;
	assign entry_valid = res_q.entry_valid;
	assign entry_key   = res_q.entry_key;
	assign entry_tag   = res_q.entry_tag;
	assign rank        = res_q.rank;
	assign last        = res_q.last;

`ifndef SYNTHESIS
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tksk_pkg::ST_READ |-> fill_q != '0)
		else $error("readout running on an empty list");

	a_fill_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cfg.cap)
		else $error("fill count above capacity");

	a_rd_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tksk_pkg::ST_READ |-> rd_idx_q < fill_q)
		else $error("readout index past fill count");

	a_no_input_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tksk_pkg::ST_READ |-> !in_ready)
		else $error("item taken during readout");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for the top-k sorted keeper: directed and random items, APB capacity setup.
module tb;
	import tksk_pkg::*;

	localparam int DEPTH = MAX_KEEP_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam logic signed [KEY_W-1:0] KEY_TOP = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic signed [KEY_W-1:0] KEY_BOTTOM = {1'b1, {(KEY_W-1){1'b0}}};

	typedef struct {
		logic                    op;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic opcode = OP_INSERT;
	logic signed [KEY_W-1:0] key_value = '0;
	logic [TAG_W-1:0] record_tag = '0;
	logic out_ready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;

	logic in_ready;
	logic out_valid;
	logic kind;
	logic dropped;
	logic [TAG_W-1:0] dropped_tag;
	logic [CNT_W-1:0] held_count;
	logic entry_valid;
	logic signed [KEY_W-1:0] entry_key;
	logic [TAG_W-1:0] entry_tag;
	logic [RANK_W-1:0] rank;
	logic last;
	logic [DATA_W-1:0] prdata;
	logic pready;

	item_t offered_items[$];
	res_t due_results[$];

	logic signed [KEY_W-1:0] top_keys [DEPTH];
	logic [TAG_W-1:0] top_tags [DEPTH];
	int top_fill = 0;
	logic [CNT_W-1:0] keep_reg = KEEP_RESET;

	int mismatches = 0;
	int src_wait = 0;
	int sink_wait = 0;
	int quiet_cycles = 0;
	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;

	top_k_sorted_keeper uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key_value(key_value),
		.record_tag(record_tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.dropped(dropped),
		.dropped_tag(dropped_tag),
		.held_count(held_count),
		.entry_valid(entry_valid),
		.entry_key(entry_key),
		.entry_tag(entry_tag),
		.rank(rank),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int usable_slots(logic [CNT_W-1:0] kc);
		if (kc == '0)
			return 1;
		if (int'(kc) > DEPTH)
			return DEPTH;
		return int'(kc);
	endfunction

	function automatic int draw_wait(bit quiet);
		if (quiet)
			return 0;
		return int'($urandom_range(0, 12));
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int v;
		v = int'($urandom_range(0, 8)) - 4;
		case ($urandom_range(0, 5))
			0: return KEY_TOP;
			1: return KEY_BOTTOM;
			2, 3: return KEY_W'(v);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void queue_item(logic op, logic signed [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag);
		item_t it;
		it.op = op;
		it.key = key;
		it.tag = tag;
		offered_items.push_back(it);
	endfunction

	function automatic void queue_random_item();
		queue_item(($urandom_range(0, 4) == 0) ? OP_READ : OP_INSERT, pick_key(),
			TAG_W'($urandom_range(0, 65535)));
	endfunction

	// Update the kept list for one item and queue the results it produces.
	function automatic void rank_and_emit(logic op, logic signed [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag);
		int cap;
		int n;
		int pos;
		int i;
		res_t r;
		cap = usable_slots(keep_reg);
		n = (top_fill > cap) ? cap : top_fill;
		r = '0;
		r.last = 1'b1;
		if (op == OP_READ) begin
			r.kind = KIND_ENTRY;
			if (n == 0)
				due_results.push_back(r);
			for (i = 0; i < n; i++) begin
				r.held_count = CNT_W'(n);
				r.entry_valid = 1'b1;
				r.entry_key = top_keys[i];
				r.entry_tag = top_tags[i];
				r.rank = RANK_W'(i);
				r.last = (i == n - 1);
				due_results.push_back(r);
			end
			return;
		end
		r.kind = KIND_INSERT;
		pos = 0;
		while (pos < n && !(top_keys[pos] < key))
			pos++;
		if (n < cap) begin
			for (i = n; i > pos; i--) begin
				top_keys[i] = top_keys[i-1];
				top_tags[i] = top_tags[i-1];
			end
			top_keys[pos] = key;
			top_tags[pos] = tag;
			n++;
		end else if (pos >= cap) begin
			r.dropped = 1'b1;
			r.dropped_tag = tag;
		end else begin
			r.dropped = 1'b1;
			r.dropped_tag = top_tags[n-1];
			for (i = n - 1; i > pos; i--) begin
				top_keys[i] = top_keys[i-1];
				top_tags[i] = top_tags[i-1];
			end
			top_keys[pos] = key;
			top_tags[pos] = tag;
		end
		top_fill = n;
		r.held_count = CNT_W'(n);
		due_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic take_result();
		res_t want;
		if (due_results.size() == 0) begin
			report_mismatch("result with nothing outstanding");
			return;
		end
		want = due_results.pop_front();
		check_field("kind", 64'(kind), 64'(want.kind));
		check_field("dropped", 64'(dropped), 64'(want.dropped));
		check_field("dropped_tag", 64'(dropped_tag), 64'(want.dropped_tag));
		check_field("held_count", 64'(held_count), 64'(want.held_count));
		check_field("entry_valid", 64'(entry_valid), 64'(want.entry_valid));
		check_field("entry_key", entry_key, want.entry_key);
		check_field("entry_tag", 64'(entry_tag), 64'(want.entry_tag));
		check_field("rank", 64'(rank), 64'(want.rank));
		check_field("last", 64'(last), 64'(want.last));
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (offered_items.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	// Write keep_count over APB, then read it back.
	task automatic write_keep(input int v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(REG_KEEP_COUNT));
		pwdata <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		keep_reg = CNT_W'(v);
		if (top_fill > usable_slots(keep_reg))
			top_fill = usable_slots(keep_reg);
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== DATA_W'(keep_reg))
			report_mismatch($sformatf("keep_count readback %h want %h", prdata, keep_reg));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : source_side
		item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_INSERT;
			key_value <= '0;
			record_tag <= '0;
			src_wait <= 0;
		end else begin
			if (in_valid && in_ready)
				rank_and_emit(opcode, key_value, record_tag);
			if (!in_valid || in_ready) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
					in_valid <= 1'b0;
				end else if (offered_items.size() != 0) begin
					it = offered_items.pop_front();
					opcode <= it.op;
					key_value <= it.key;
					record_tag <= it.tag;
					in_valid <= 1'b1;
					src_wait <= draw_wait(src_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : sink_side
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else if (out_valid && out_ready) begin
			take_result();
			w = draw_wait(sink_quiet);
			sink_wait <= w;
			out_ready <= (w == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			out_ready <= (sink_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int plan [7];
		int p;
		int k;
		plan = '{16, 3, 1, 17, 31, 8, 0};
		plan[6] = int'($urandom_range(0, 31));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		queue_item(OP_READ, KEY_TOP, 16'h1234);
		queue_item(OP_INSERT, KEY_TOP, 16'hFFFF);
		queue_item(OP_INSERT, KEY_BOTTOM, 16'h0000);
		queue_item(OP_INSERT, KEY_W'(0), 16'h0010);
		queue_item(OP_INSERT, KEY_W'(-1), 16'h0011);
		queue_item(OP_INSERT, KEY_W'(5), 16'h00A0);
		queue_item(OP_INSERT, KEY_W'(5), 16'h00B0);
		queue_item(OP_READ, KEY_BOTTOM, 16'hFFFF);
		wait_idle();

		// shrink: entries past two are cut off
		write_keep(2);
		wait_idle();
		queue_item(OP_READ, '0, '0);
		queue_item(OP_INSERT, KEY_W'(100), 16'h00C0);
		queue_item(OP_INSERT, KEY_W'(100), 16'h00C1);
		queue_item(OP_INSERT, KEY_W'(-7), 16'h00C2);
		queue_item(OP_READ, '0, '0);
		wait_idle();

		write_keep(0);
		wait_idle();
		queue_item(OP_READ, '0, '0);
		queue_item(OP_INSERT, KEY_TOP, 16'h00D0);
		queue_item(OP_INSERT, KEY_BOTTOM, 16'h00D1);
		queue_item(OP_READ, '0, '0);
		wait_idle();

		write_keep(31);
		wait_idle();
		queue_item(OP_INSERT, KEY_W'(3), 16'h00E0);
		queue_item(OP_INSERT, KEY_W'(-3), 16'h00E1);
		queue_item(OP_INSERT, KEY_W'(3), 16'h00E2);
		queue_item(OP_READ, '0, '0);
		wait_idle();

		for (p = 0; p < 7; p++) begin
			write_keep(plan[p]);
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			wait_idle();
			for (k = 0; k < 15; k++) begin
				queue_random_item();
				// hold the sender until the list has fully answered
				if (p == 2 && k == 9)
					wait_idle();
			end
			queue_item(OP_READ, '0, '0);
			wait_idle();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
